>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the key event encoder; kevt_serializer includes them.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge, ignored while reset is high.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
// Check that also holds while reset is high.
`define ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed: label");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_RESET(label, clk, prop)
`endif
`endif

>>> hw/rtl/kevt_pkg.sv
// Package for the key event to VT100 byte encoder: key codes, byte codes and types.
// Used by kevt_decode, kevt_serializer and key_event_to_vt100_bytes.
`timescale 1ns / 1ps
package kevt_pkg;

   localparam int unsigned MaxBytes = 5;
   localparam int unsigned LenWidth = 3;

   // Key codes of the keyboard event.
   localparam logic [7:0] CODE_CTRL  = 8'hA5;
   localparam logic [7:0] CODE_ESC   = 8'hB1;
   localparam logic [7:0] CODE_LEFT  = 8'hB4;
   localparam logic [7:0] CODE_UP    = 8'hB5;
   localparam logic [7:0] CODE_DOWN  = 8'hB6;
   localparam logic [7:0] CODE_RIGHT = 8'hB7;
   localparam logic [7:0] CODE_F1    = 8'h81;
   localparam logic [7:0] CODE_F4    = 8'h84;
   localparam logic [7:0] CODE_F5    = 8'h85;
   localparam logic [7:0] CODE_F6    = 8'h86;
   localparam logic [7:0] CODE_F7    = 8'h87;
   localparam logic [7:0] CODE_F8    = 8'h88;
   localparam logic [7:0] CODE_F9    = 8'h89;
   localparam logic [7:0] CODE_F10   = 8'h90;

   // Key states.
   localparam logic [7:0] ST_PRESS   = 8'd1;
   localparam logic [7:0] ST_HOLD    = 8'd2;
   localparam logic [7:0] ST_RELEASE = 8'd3;

   // Terminal bytes.
   localparam logic [7:0] VIEW_UP   = 8'hF0;
   localparam logic [7:0] VIEW_DOWN = 8'hF1;
   localparam logic [7:0] ESC_BYTE  = 8'h1B;
   localparam logic [7:0] CHR_O     = 8'h4F;
   localparam logic [7:0] CHR_LBRK  = 8'h5B;
   localparam logic [7:0] CHR_TILDE = 8'h7E;
   localparam logic [7:0] CHR_A     = 8'h41;
   localparam logic [7:0] CHR_B     = 8'h42;
   localparam logic [7:0] CHR_C     = 8'h43;
   localparam logic [7:0] CHR_D     = 8'h44;
   localparam logic [7:0] CHR_LOW_A = 8'h61;
   localparam logic [7:0] CHR_LOW_Z = 8'h7A;
   // Offset from a function key code F1..F4 to the SS3 final byte P..S.
   localparam logic [7:0] SS3_OFFSET = 8'h31;
   // Offset from a lower-case letter to its control code.
   localparam logic [7:0] CTRL_OFFSET = 8'h60;

   // Byte sequence of one event, first byte in entry 0.
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [LenWidth-1:0]      len;
   } seq_type;

   // Two parameter digits of the tilde sequence, F5..F9 as 0..4 and F10 as 5.
   function automatic logic [15:0] tilde_digits(input logic [2:0] idx);
      logic [15:0] d;
      case (idx)
         3'd0:    d = {8'h35, 8'h31};
         3'd1:    d = {8'h37, 8'h31};
         3'd2:    d = {8'h38, 8'h31};
         3'd3:    d = {8'h39, 8'h31};
         3'd4:    d = {8'h30, 8'h32};
         default: d = {8'h31, 8'h32};
      endcase
      return d;
   endfunction

endpackage

>>> hw/rtl/key_event_to_vt100_bytes.sv
// The first byte of a request passes the input register and then the output shift register;
// it moves on from the input register only when the output register is free.
// Throughput: one request per cycle for single-byte sequences while every byte is taken;
// a sequence of N bytes (1, 3 or 5) holds the output register until its last byte is taken.
// Requests that make no bytes leave the input register when the output is free.
// Reset (synchronous, active high) empties both registers and clears the control flag.
`timescale 1ns / 1ps
module key_event_to_vt100_bytes import kevt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // event code[7:0], event state[15:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast    // last_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] state_ff, state_in;
   logic       free;
   logic       load;
   seq_type    seq;

   // Input register: moves on to decode when the output register is free.
   assign load       = valid_ff && free;
   assign req_tready = !valid_ff || load;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      state_in = state_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         code_in  = req_tdata[7:0];
         state_in = req_tdata[15:8];
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff  <= code_in;
      state_ff <= state_in;
   end

   kevt_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .evt_code  (code_ff),
      .evt_state (state_ff),
      .seq       (seq)
   );

   kevt_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .seq        (seq),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hw/rtl/kevt_decode.sv
// Event decoder: turns one key event into its byte sequence and tracks the control flag.
// Depends on kevt_pkg.
`timescale 1ns / 1ps
module kevt_decode import kevt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,       // event leaves the input register this cycle
   input  logic [7:0] evt_code,
   input  logic [7:0] evt_state,
   output seq_type    seq
);

   logic ctrl_held_ff;
   logic ctrl_held_in;

   // Control flag: updated only when a control event is taken.
   always_comb begin
      ctrl_held_in = ctrl_held_ff;
      if (load && evt_code == CODE_CTRL) begin
         if (evt_state == ST_PRESS) begin
            ctrl_held_in = 1'b1;
         end else if (evt_state == ST_RELEASE) begin
            ctrl_held_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_held_ff <= 1'b0;
      end else begin
         ctrl_held_ff <= ctrl_held_in;
      end
   end

   // Sequence lookup for the event.
   always_comb begin
      logic        active;
      logic [2:0]  tidx;
      logic [15:0] digits;
      active = (evt_state == ST_PRESS) || (evt_state == ST_HOLD);
      tidx   = (evt_code == CODE_F10) ? 3'd5 : 3'(evt_code - CODE_F5);
      digits = tilde_digits(tidx);
      seq.bytes    = '0;
      seq.bytes[0] = ESC_BYTE;
      seq.len      = '0;
      if ((evt_code == 8'd0 && evt_state == 8'd0) || evt_code == CODE_CTRL || !active) begin
         seq.len = '0;
      end else if (evt_code == CODE_ESC) begin
         seq.len = LenWidth'(1);
      end else if (evt_code >= CODE_F1 && evt_code <= CODE_F4) begin
         seq.bytes[1] = CHR_O;
         seq.bytes[2] = evt_code - SS3_OFFSET;
         seq.len      = LenWidth'(3);
      end else if ((evt_code >= CODE_F5 && evt_code <= CODE_F9) || evt_code == CODE_F10) begin
         seq.bytes[1] = CHR_LBRK;
         seq.bytes[2] = digits[7:0];
         seq.bytes[3] = digits[15:8];
         seq.bytes[4] = CHR_TILDE;
         seq.len      = LenWidth'(5);
      end else if (ctrl_held_ff && evt_code == CODE_UP) begin
         seq.bytes[0] = VIEW_UP;
         seq.len      = LenWidth'(1);
      end else if (ctrl_held_ff && evt_code == CODE_DOWN) begin
         seq.bytes[0] = VIEW_DOWN;
         seq.len      = LenWidth'(1);
      end else if (evt_code == CODE_UP || evt_code == CODE_DOWN ||
                   evt_code == CODE_RIGHT || evt_code == CODE_LEFT) begin
         seq.bytes[1] = CHR_LBRK;
         case (evt_code)
            CODE_UP:    seq.bytes[2] = CHR_A;
            CODE_DOWN:  seq.bytes[2] = CHR_B;
            CODE_RIGHT: seq.bytes[2] = CHR_C;
            default:    seq.bytes[2] = CHR_D;
         endcase
         seq.len = LenWidth'(3);
      end else if (ctrl_held_ff && evt_code >= CHR_LOW_A && evt_code <= CHR_LOW_Z) begin
         seq.bytes[0] = evt_code - CTRL_OFFSET;
         seq.len      = LenWidth'(1);
      end else begin
         seq.bytes[0] = evt_code;
         seq.len      = LenWidth'(1);
      end
   end

endmodule

>>> hw/rtl/kevt_serializer.sv
// Output shift register: holds one byte sequence and sends it one byte per cycle while the receiver is ready.
// Depends on kevt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kevt_serializer import kevt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,       // take a decoded sequence this cycle
   input  seq_type    seq,
   output logic       free,       // register can take a sequence this cycle
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // out_byte[7:0]
   output logic       rsp_tlast   // last_byte
);

   logic [MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic [LenWidth-1:0]      cnt_ff, cnt_in;
   logic                     fire;

   assign fire       = rsp_tvalid && rsp_tready;
   assign free       = (cnt_ff == '0) || (fire && cnt_ff == LenWidth'(1));
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = bytes_ff[0];
   assign rsp_tlast  = (cnt_ff == LenWidth'(1));

   // Load a new sequence or shift the sent byte out.
   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         bytes_in = seq.bytes;
         cnt_in   = seq.len;
      end else if (fire) begin
         bytes_in = {8'h00, bytes_ff[MaxBytes-1:1]};
         cnt_in   = cnt_ff - LenWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bytes_ff <= bytes_in;
   end

   // The count never exceeds the longest sequence; before the first reset edge it is unknown.
   `ASSERT_RESET(a_cnt_range, clock, reset || cnt_ff <= LenWidth'(MaxBytes))
   // A sequence is only loaded when the previous one is done.
   `ASSERT_ALWAYS(a_load_free, clock, reset, load |-> free)
   // A byte taken mid-sequence steps the count down by one.
   `ASSERT_ALWAYS(a_step, clock, reset,
      (fire && !rsp_tlast) |=> (cnt_ff == $past(cnt_ff) - LenWidth'(1)))

endmodule

>>> dv/tb_key_event_to_vt100_bytes.sv
// Self-checking testbench for key_event_to_vt100_bytes: drives keyboard events
// and checks every terminal byte against an in-bench encoder model.
// Depends on kevt_pkg and the key_event_to_vt100_bytes RTL.
`timescale 1ns / 1ps
module tb_key_event_to_vt100_bytes import kevt_pkg::*; ();

   // One terminal byte as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } term_byte_type;

   localparam int unsigned MaxReported = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;   // event code[7:0], event state[15:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;              // out_byte[7:0]
   logic        rsp_tlast;              // last_byte

   logic [15:0]   key_events_to_send [$];
   term_byte_type expected_term_bytes [$];
   logic          ctrl_held_model = 1'b0;
   logic          req_fire = 1'b0;
   int unsigned   events_queued = 0;
   int unsigned   events_accepted = 0;
   int unsigned   bytes_checked = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;

   key_event_to_vt100_bytes u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Encoder model: updates the control flag and queues the bytes one event makes.
   function automatic void encode_key_event(input logic [7:0] code, input logic [7:0] state);
      logic [7:0]    seq [0:4];
      int unsigned   len;
      term_byte_type tb;
      len = 0;
      if (code == 8'h00 && state == 8'h00) return;
      if (code == CODE_CTRL) begin
         if (state == ST_PRESS) ctrl_held_model = 1'b1;
         else if (state == ST_RELEASE) ctrl_held_model = 1'b0;
         return;
      end
      if (state != ST_PRESS && state != ST_HOLD) return;
      seq[0] = ESC_BYTE;
      if (code == CODE_ESC) begin
         len = 1;
      end else if (code >= CODE_F1 && code <= CODE_F4) begin
         // SS3 final byte runs from 'P' upward.
         seq[1] = CHR_O;
         seq[2] = "P" + (code - CODE_F1);
         len = 3;
      end else if ((code >= CODE_F5 && code <= CODE_F9) || code == CODE_F10) begin
         seq[1] = CHR_LBRK;
         seq[4] = CHR_TILDE;
         // Two ASCII parameter digits: 15, 17, 18, 19, 20, 21.
         case (code)
            CODE_F5: begin seq[2] = "1"; seq[3] = "5"; end
            CODE_F6: begin seq[2] = "1"; seq[3] = "7"; end
            CODE_F7: begin seq[2] = "1"; seq[3] = "8"; end
            CODE_F8: begin seq[2] = "1"; seq[3] = "9"; end
            CODE_F9: begin seq[2] = "2"; seq[3] = "0"; end
            default: begin seq[2] = "2"; seq[3] = "1"; end
         endcase
         len = 5;
      end else if (code == CODE_UP || code == CODE_DOWN || code == CODE_LEFT ||
                   code == CODE_RIGHT) begin
         if (ctrl_held_model && code == CODE_UP) begin
            seq[0] = VIEW_UP;
            len = 1;
         end else if (ctrl_held_model && code == CODE_DOWN) begin
            seq[0] = VIEW_DOWN;
            len = 1;
         end else begin
            seq[1] = CHR_LBRK;
            case (code)
               CODE_UP:    seq[2] = CHR_A;
               CODE_DOWN:  seq[2] = CHR_B;
               CODE_RIGHT: seq[2] = CHR_C;
               default:    seq[2] = CHR_D;
            endcase
            len = 3;
         end
      end else begin
         // Plain pass-through, with lower-case letters folded to control codes.
         if (ctrl_held_model && code >= CHR_LOW_A && code <= CHR_LOW_Z)
            seq[0] = code - CTRL_OFFSET;
         else
            seq[0] = code;
         len = 1;
      end
      for (int unsigned k = 0; k < len; k++) begin
         tb.out_byte  = seq[k];
         tb.last_byte = (k == len - 1);
         expected_term_bytes.push_back(tb);
      end
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MaxReported) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   // Random key event, weighted toward keys that make sequences.
   function automatic logic [15:0] random_key_event();
      logic [7:0]  code;
      logic [7:0]  state;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         code = CODE_CTRL;
      end else if (pick < 45) begin
         case ($urandom_range(3))
            0:       code = CODE_ESC;
            1:       code = 8'($urandom_range(8'h81, 8'h90));
            2:       code = 8'($urandom_range(8'hB4, 8'hB7));
            default: code = 8'($urandom_range(8'hB0, 8'hB8));
         endcase
      end else if (pick < 70) begin
         code = 8'($urandom_range(8'h60, 8'h7B));
      end else begin
         code = 8'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 40) state = ST_PRESS;
      else if (pick < 65) state = ST_HOLD;
      else if (pick < 85) state = ST_RELEASE;
      else state = 8'($urandom_range(255));
      if ($urandom_range(49) == 0) begin
         code  = 8'h00;
         state = 8'h00;
      end
      return {state, code};
   endfunction

   // Request driver and result ready, both changing at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (key_events_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata  <= key_events_to_send.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted byte.
   always @(posedge clock) begin
      term_byte_type want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            encode_key_event(req_tdata[7:0], req_tdata[15:8]);
            events_accepted <= events_accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked <= bytes_checked + 1;
            if (expected_term_bytes.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
            end else begin
               want = expected_term_bytes.pop_front();
               if (rsp_tdata !== want.out_byte || rsp_tlast !== want.last_byte)
                  note_mismatch($sformatf("byte expected %02h last %0b, got %02h last %0b",
                     want.out_byte, want.last_byte, rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   task automatic queue_event(input logic [7:0] code, input logic [7:0] state);
      key_events_to_send.push_back({state, code});
      events_queued++;
   endtask

   // Wait until every queued event is taken and every expected byte has come out.
   task automatic drain();
      while (events_accepted != events_queued || expected_term_bytes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Stimulus: directed events, then random events under four handshake phases.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty event, code zero, every key class, control on and off.
      queue_event(8'h00, 8'h00);
      queue_event(8'h00, ST_PRESS);
      queue_event(8'hFF, ST_HOLD);
      queue_event(CODE_ESC, ST_PRESS);
      queue_event(CODE_F1, ST_PRESS);
      queue_event(CODE_F4, ST_HOLD);
      queue_event(CODE_F5, ST_PRESS);
      queue_event(CODE_F9, ST_PRESS);
      queue_event(CODE_F10, ST_HOLD);
      queue_event(8'h8A, ST_PRESS);
      queue_event(8'h8F, ST_PRESS);
      queue_event(CODE_UP, ST_PRESS);
      queue_event(CODE_DOWN, ST_PRESS);
      queue_event(CODE_LEFT, ST_HOLD);
      queue_event(CODE_RIGHT, ST_PRESS);
      queue_event(CODE_CTRL, ST_PRESS);
      queue_event(CHR_LOW_A, ST_PRESS);
      queue_event(CHR_LOW_Z, ST_HOLD);
      queue_event(8'h60, ST_PRESS);
      queue_event(8'h7B, ST_PRESS);
      queue_event(CODE_UP, ST_PRESS);
      queue_event(CODE_DOWN, ST_HOLD);
      // Control with a hold state keeps the flag; releases and odd states emit nothing.
      queue_event(CODE_CTRL, ST_HOLD);
      queue_event(8'h62, ST_RELEASE);
      queue_event(8'h63, 8'hFF);
      queue_event(CODE_CTRL, ST_RELEASE);
      queue_event(CHR_LOW_A, ST_PRESS);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int i = 0; i < (phase == 0 ? 25 : 50); i++)
            key_events_to_send.push_back(random_key_event());
         events_queued += (phase == 0 ? 25 : 50);
         drain();
      end

      $display("Encoded %0d key events into %0d terminal bytes under four handshake phases.",
         events_accepted, bytes_checked);
      $display("Byte or last-flag errors seen: %0d.", mismatch_count);
      if (mismatch_count == 0 && expected_term_bytes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
